/* src/eo_pkg.sv */
// Shared types, constants and tables for the encoder odometry block.
package eo_pkg;

   localparam int COUNT_BITS_DEF   = 32;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_MAX_STEPS = 24;
   localparam int STEP_BITS        = $clog2(CORDIC_MAX_STEPS);

   localparam int XY_BITS = 27;
   localparam int Z_BITS  = 34;

   localparam int REQ_DATA_BITS = 104;
   localparam int RSP_DATA_BITS = 216;

   localparam logic signed [XY_BITS-1:0] CORDIC_GAIN_Q24 = XY_BITS'(10188014);
   localparam logic [17:0] INV_TWO_PI_Q20 = 18'd166886;
   localparam logic [9:0]  MS_PER_S       = 10'd1000;
   localparam logic signed [64:0] DELTA_MAX = 65'sd8388607;
   localparam logic signed [64:0] DELTA_MIN = -65'sd8388608;

   localparam logic [31:0] ATAN_TAB [CORDIC_MAX_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   localparam logic CSR_MM_PER_PULSE = 1'b0;
   localparam logic CSR_AXLE_LENGTH  = 1'b1;

   typedef enum logic [1:0] {
      REQ_LEFT  = 2'd0,
      REQ_RIGHT = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_LOAD  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV_TRUNC,
      ALU_DIV_FLOOR
   } alu_op_type;

   typedef enum logic [1:0] {
      UNIT_IDLE,
      UNIT_RUN,
      UNIT_FIN
   } unit_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADV,
      ST_DA1,
      ST_DA2,
      ST_DA3,
      ST_COR,
      ST_MS,
      ST_MC,
      ST_LS1,
      ST_LS2,
      ST_AS1,
      ST_AS2,
      ST_LA,
      ST_AA,
      ST_OUT
   } seq_state_type;

endpackage

/* src/eo_alu.sv */
// Shared bit-serial multiply and divide unit on signed 64-bit operands.
module eo_alu import eo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  alu_op_type         op,
   input  logic signed [63:0] opa,
   input  logic signed [63:0] opb,
   output logic               done,
   output logic signed [63:0] result
);

   unit_state_type state_ff, state_in;
   alu_op_type     op_ff, op_in;
   logic [63:0]    ma_ff, ma_in, mb_ff, mb_in, acc_ff, acc_in, rem_ff, rem_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic           neg_ff, neg_in;
   logic [65:0]    trial;
   logic [63:0]    mag;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         UNIT_IDLE: if (start) state_in = UNIT_RUN;
         UNIT_RUN: begin
            if (op_ff == ALU_MUL) begin
               if (mb_ff == '0) state_in = UNIT_FIN;
            end else if (cnt_ff == '0) begin
               state_in = UNIT_FIN;
            end
         end
         UNIT_FIN: state_in = UNIT_IDLE;
         default: state_in = UNIT_IDLE;
      endcase
   end

   // Datapath: shift-add multiply or restoring division, one bit a cycle.
   always_comb begin
      op_in  = op_ff;
      ma_in  = ma_ff;
      mb_in  = mb_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      trial  = {1'b0, rem_ff, ma_ff[63]} - {2'b00, mb_ff};
      if (state_ff == UNIT_IDLE && start) begin
         op_in  = op;
         ma_in  = opa[63] ? 64'(-opa) : 64'(opa);
         mb_in  = opb[63] ? 64'(-opb) : 64'(opb);
         acc_in = '0;
         rem_in = '0;
         cnt_in = '1;
         neg_in = opa[63] ^ opb[63];
      end else if (state_ff == UNIT_RUN) begin
         if (op_ff == ALU_MUL) begin
            if (mb_ff != '0) begin
               if (mb_ff[0]) acc_in = acc_ff + ma_ff;
               ma_in = {ma_ff[62:0], 1'b0};
               mb_in = {1'b0, mb_ff[63:1]};
            end
         end else begin
            if (!trial[65]) begin
               rem_in = trial[63:0];
               ma_in  = {ma_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], ma_ff[63]};
               ma_in  = {ma_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   // Outputs: the sign is put back, and a floor quotient steps down on a remainder.
   always_comb begin
      done = (state_ff == UNIT_FIN);
      mag  = (op_ff == ALU_MUL) ? acc_ff : ma_ff;
      if (!neg_ff) begin
         result = $signed(mag);
      end else if (op_ff == ALU_DIV_FLOOR && rem_ff != '0) begin
         result = $signed(~mag);
      end else begin
         result = $signed(-mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UNIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

endmodule

/* src/eo_cordic.sv */
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle in Q24.
module eo_cordic import eo_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [15:0]               angle,
   output logic                      done,
   output logic signed [XY_BITS-1:0] cos_out,
   output logic signed [XY_BITS-1:0] sin_out
);

   unit_state_type            state_ff, state_in;
   logic signed [XY_BITS-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [Z_BITS-1:0]  z_ff, z_in, at;
   logic [STEP_BITS-1:0]      i_ff, i_in;
   logic                      flip_ff, flip_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         UNIT_IDLE: if (start) state_in = UNIT_RUN;
         UNIT_RUN:  if (i_ff == STEP_BITS'(STEPS - 1)) state_in = UNIT_FIN;
         UNIT_FIN:  state_in = UNIT_IDLE;
         default:   state_in = UNIT_IDLE;
      endcase
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      flip_in = flip_ff;
      xs      = x_ff >>> i_ff;
      ys      = y_ff >>> i_ff;
      at      = $signed({2'b00, ATAN_TAB[i_ff]});
      if (state_ff == UNIT_IDLE && start) begin
         // Angles in the back half-turn are rotated by a half-turn and negated after.
         flip_in = angle[15] ^ angle[14];
         z_in    = Z_BITS'($signed({angle[14], angle[14:0], 16'h0000}));
         x_in    = CORDIC_GAIN_Q24;
         y_in    = '0;
         i_in    = '0;
      end else if (state_ff == UNIT_RUN) begin
         if (!z_ff[Z_BITS-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         i_in = i_ff + STEP_BITS'(1);
      end
   end

   always_comb begin
      done    = (state_ff == UNIT_FIN);
      cos_out = flip_ff ? -x_ff : x_ff;
      sin_out = flip_ff ? -y_ff : y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UNIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      i_ff    <= i_in;
      flip_ff <= flip_in;
   end

endmodule

/* src/encoder_odometry_top.sv */
// Top level of the encoder odometry block: wheel counters, pose, sequencer and result register.
// Dead-reckoning odometry for a two-wheel robot. Edge words (left or right) move a wheel count
// up when the A and B levels are equal and down otherwise; load words set the pose. Both are
// taken only while the sequencer is idle and give no result. An update tick takes the wheel
// deltas since the last tick, works out the advance and heading change, rotates the advance by
// the new heading and moves the pose, then forms speeds and accelerations and delivers one
// result word. All multiplies and divides of a tick run one after another on a single
// bit-serial unit. When elapsed_ms is zero, the speed and acceleration steps are skipped. A
// tick occupies the block until its result is registered, and req_tready stays low meanwhile.
// The result register lets a tick finish while the previous result still waits, but a tick
// only completes once that register is free.
module encoder_odometry_top import eo_pkg::*; #(
   parameter int COUNT_BITS   = COUNT_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // chan_a, chan_b, elapsed_ms[15:0], new_x[31:0], new_y[31:0], new_heading[15:0], zeros
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pos_x, pos_y, heading, linear_speed, angular_speed, linear_accel, angular_accel,
   // zero_interval, zeros
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [19:0]              csr_data
);

   seq_state_type           state_ff, state_in;
   logic                    issued_ff, issued_in;
   logic [COUNT_BITS-1:0]   lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   logic [COUNT_BITS-1:0]   lseen_ff, lseen_in, rseen_ff, rseen_in;
   logic [31:0]             x_ff, x_in, y_ff, y_in;
   logic [15:0]             angle_ff, angle_in;
   logic signed [31:0]      lspd_ff, lspd_in, aspd_ff, aspd_in;
   logic signed [31:0]      lacc_ff, lacc_in, aacc_ff, aacc_in;
   logic [19:0]             mpp_ff, mpp_in;
   logic [15:0]             axle_ff, axle_in;
   logic signed [24:0]      dsum_ff, dsum_in, ddif_ff, ddif_in;
   logic [15:0]             el_ff, el_in;
   logic signed [63:0]      prod_ff, prod_in, adv_ff, adv_in, dang_ff, dang_in;
   logic signed [63:0]      ls_ff, ls_in, as_ff, as_in;
   logic signed [XY_BITS-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                    req_accept, up;
   req_kind_type            kind;
   logic [COUNT_BITS-1:0]   step, ldiff, rdiff;
   logic signed [23:0]      dl, dr;
   logic                    alu_start, alu_done, cor_start, cor_done;
   alu_op_type              alu_op;
   logic signed [63:0]      alu_a, alu_b, alu_res, shr24;
   logic signed [XY_BITS-1:0] cor_cos, cor_sin;
   logic [15:0]             axle_eff;
   logic                    zero_el, out_free;
   logic signed [31:0]      out_lspd, out_aspd;

   function automatic logic signed [23:0] sat_delta(input logic signed [64:0] v);
      if (v > DELTA_MAX) return 24'sd8388607;
      if (v < DELTA_MIN) return -24'sd8388608;
      return v[23:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign kind       = req_kind_type'(req_tuser);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Wheel deltas since the last tick, signed in the counter width and then clamped.
   assign up    = (req_tdata[0] == req_tdata[1]);
   assign step  = up ? COUNT_BITS'(1) : '1;
   assign ldiff = lcnt_ff - lseen_ff;
   assign rdiff = rcnt_ff - rseen_ff;
   assign dl    = sat_delta(65'($signed(ldiff)));
   assign dr    = sat_delta(65'($signed(rdiff)));

   assign axle_eff = (axle_ff == '0) ? 16'd1 : axle_ff;
   assign zero_el  = (el_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign shr24    = alu_res >>> 24;
   assign out_lspd = zero_el ? lspd_ff : sat32(ls_ff);
   assign out_aspd = zero_el ? aspd_ff : sat32(as_ff);

   eo_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_res)
   );

   eo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (angle_ff),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   // Next state of the tick sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_accept && kind == REQ_TICK) state_in = ST_ADV;
         ST_ADV:  if (alu_done) state_in = ST_DA1;
         ST_DA1:  if (alu_done) state_in = ST_DA2;
         ST_DA2:  if (alu_done) state_in = ST_DA3;
         ST_DA3:  if (alu_done) state_in = ST_COR;
         ST_COR:  if (cor_done) state_in = ST_MS;
         ST_MS:   if (alu_done) state_in = ST_MC;
         ST_MC:   if (alu_done) state_in = zero_el ? ST_OUT : ST_LS1;
         ST_LS1:  if (alu_done) state_in = ST_LS2;
         ST_LS2:  if (alu_done) state_in = ST_AS1;
         ST_AS1:  if (alu_done) state_in = ST_AS2;
         ST_AS2:  if (alu_done) state_in = ST_LA;
         ST_LA:   if (alu_done) state_in = ST_AA;
         ST_AA:   if (alu_done) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Operands for the shared unit in each step.
   always_comb begin
      alu_op = ALU_MUL;
      alu_a  = prod_ff;
      alu_b  = 64'(el_ff);
      unique case (state_ff)
         ST_ADV: begin
            alu_a = 64'(dsum_ff);
            alu_b = 64'(mpp_ff);
         end
         ST_DA1: begin
            alu_a = 64'(ddif_ff);
            alu_b = 64'(mpp_ff);
         end
         ST_DA2: alu_b = 64'(INV_TWO_PI_Q20);
         ST_DA3: begin
            alu_op = ALU_DIV_FLOOR;
            alu_b  = 64'({axle_eff, 12'h000});
         end
         ST_MS: begin
            alu_a = adv_ff;
            alu_b = 64'(sin_ff);
         end
         ST_MC: begin
            alu_a = adv_ff;
            alu_b = 64'(cos_ff);
         end
         ST_LS1: begin
            alu_a = adv_ff;
            alu_b = 64'(MS_PER_S);
         end
         ST_AS1: begin
            alu_a = dang_ff;
            alu_b = 64'(MS_PER_S);
         end
         ST_LS2, ST_AS2: alu_op = ALU_DIV_TRUNC;
         ST_LA: begin
            alu_op = ALU_DIV_TRUNC;
            alu_a  = ls_ff - 64'(lspd_ff);
         end
         ST_AA: begin
            alu_op = ALU_DIV_TRUNC;
            alu_a  = as_ff - 64'(aspd_ff);
         end
         default: alu_op = ALU_MUL;
      endcase
      cor_start = (state_ff == ST_COR) && !issued_ff;
      alu_start = (state_ff != ST_IDLE) && (state_ff != ST_COR) &&
                  (state_ff != ST_OUT) && !issued_ff;
      issued_in = issued_ff;
      if (alu_done || cor_done) begin
         issued_in = 1'b0;
      end else if (alu_start || cor_start) begin
         issued_in = 1'b1;
      end
   end

   // Datapath registers.
   always_comb begin
      lcnt_in      = lcnt_ff;
      rcnt_in      = rcnt_ff;
      lseen_in     = lseen_ff;
      rseen_in     = rseen_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      angle_in     = angle_ff;
      lspd_in      = lspd_ff;
      aspd_in      = aspd_ff;
      lacc_in      = lacc_ff;
      aacc_in      = aacc_ff;
      mpp_in       = mpp_ff;
      axle_in      = axle_ff;
      dsum_in      = dsum_ff;
      ddif_in      = ddif_ff;
      el_in        = el_ff;
      prod_in      = prod_ff;
      adv_in       = adv_ff;
      dang_in      = dang_ff;
      ls_in        = ls_ff;
      as_in        = as_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MM_PER_PULSE: mpp_in  = csr_data;
            CSR_AXLE_LENGTH:  axle_in = csr_data[15:0];
            default:          mpp_in  = mpp_ff;
         endcase
      end

      if (req_accept) begin
         unique case (kind)
            REQ_LEFT:  lcnt_in = lcnt_ff + step;
            REQ_RIGHT: rcnt_in = rcnt_ff + step;
            REQ_LOAD: begin
               x_in     = req_tdata[49:18];
               y_in     = req_tdata[81:50];
               angle_in = req_tdata[97:82];
            end
            REQ_TICK: begin
               dsum_in  = 25'(dl) + 25'(dr);
               ddif_in  = 25'(dr) - 25'(dl);
               el_in    = req_tdata[17:2];
               lseen_in = lcnt_ff;
               rseen_in = rcnt_ff;
            end
            default: el_in = el_ff;
         endcase
      end

      if (alu_done) begin
         unique case (state_ff)
            ST_ADV: adv_in = alu_res >>> 9;
            ST_DA3: begin
               dang_in  = alu_res;
               angle_in = angle_ff + alu_res[15:0];
            end
            ST_MS: x_in = x_ff - shr24[31:0];
            ST_MC: begin
               y_in = y_ff + shr24[31:0];
               // No interval: speeds are held and both accelerations read zero.
               lacc_in = '0;
               aacc_in = '0;
            end
            ST_LS2: ls_in = alu_res;
            ST_AS2: as_in = alu_res;
            ST_LA:  lacc_in = sat32(alu_res);
            ST_AA:  aacc_in = sat32(alu_res);
            default: prod_in = alu_res;
         endcase
      end

      if (cor_done) begin
         cos_in = cor_cos;
         sin_in = cor_sin;
      end

      if (state_ff == ST_OUT && out_free) begin
         lspd_in      = out_lspd;
         aspd_in      = out_aspd;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'b0, zero_el, aacc_ff, lacc_ff, out_aspd, out_lspd,
                         angle_ff, y_ff, x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         lcnt_ff      <= '0;
         rcnt_ff      <= '0;
         lseen_ff     <= '0;
         rseen_ff     <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         angle_ff     <= '0;
         lspd_ff      <= '0;
         aspd_ff      <= '0;
         mpp_ff       <= 20'd6554;
         axle_ff      <= 16'd17920;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         lcnt_ff      <= lcnt_in;
         rcnt_ff      <= rcnt_in;
         lseen_ff     <= lseen_in;
         rseen_ff     <= rseen_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         angle_ff     <= angle_in;
         lspd_ff      <= lspd_in;
         aspd_ff      <= aspd_in;
         mpp_ff       <= mpp_in;
         axle_ff      <= axle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lacc_ff     <= lacc_in;
      aacc_ff     <= aacc_in;
      dsum_ff     <= dsum_in;
      ddif_ff     <= ddif_in;
      el_ff       <= el_in;
      prod_ff     <= prod_in;
      adv_ff      <= adv_in;
      dang_ff     <= dang_in;
      ls_ff       <= ls_in;
      as_ff       <= as_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the encoder odometry block, with its own pose predictor.
import eo_pkg::*;

// The expected pose and speeds of one update tick.
typedef struct {
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [15:0] heading;
   logic [31:0] linear_speed;
   logic [31:0] angular_speed;
   logic [31:0] linear_accel;
   logic [31:0] angular_accel;
   logic        zero_interval;
} odo_pose_t;

// Predicts the pose from accepted words and checks each delivered result against it.
class odometry_scoreboard;
   logic [19:0]     mm_per_pulse;
   logic [15:0]     axle_length;
   logic [31:0]     left_count, right_count, left_seen, right_seen;
   logic [31:0]     x_pos, y_pos;
   logic [15:0]     angle;
   longint          lin_speed, ang_speed;
   odo_pose_t       pending_poses[$];
   int              fails;

   function void clear();
      mm_per_pulse = 20'd6554;
      axle_length  = 16'd17920;
      left_count   = '0;
      right_count  = '0;
      left_seen    = '0;
      right_seen   = '0;
      x_pos        = '0;
      y_pos        = '0;
      angle        = '0;
      lin_speed    = 0;
      ang_speed    = 0;
      fails        = 0;
      pending_poses.delete();
   endfunction

   function void set_register(logic index, logic [19:0] value);
      if (index == CSR_MM_PER_PULSE) mm_per_pulse = value;
      else axle_length = value[15:0];
   endfunction

   // Signed count difference since the last tick, clamped to 24 bits.
   function longint wheel_delta(logic [31:0] now, logic [31:0] seen);
      logic [31:0] diff;
      longint      d;
      diff = now - seen;
      d = longint'(signed'(diff));
      if (d > 64'sd8388607) d = 64'sd8388607;
      if (d < -64'sd8388608) d = -64'sd8388608;
      return d;
   endfunction

   function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if (n % d != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Rotation of the gain-corrected unit vector to the heading, Q24 cosine and sine.
   function void rotate(logic [15:0] ang, output longint cos_q, output longint sin_q);
      logic [31:0] a;
      bit          flip;
      longint      x, y, z, nx;
      a = {ang, 16'h0000};
      flip = 1'b0;
      if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
         a = a - 32'h8000_0000;
         flip = 1'b1;
      end
      z = longint'(signed'(a));
      x = 64'sd10188014;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(ATAN_TAB[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(ATAN_TAB[i]);
         end
         x = nx;
      end
      cos_q = flip ? -x : x;
      sin_q = flip ? -y : y;
   endfunction

   function void note_word(req_kind_type kind, logic a, logic b, logic [15:0] elapsed,
                           logic [31:0] new_x, logic [31:0] new_y, logic [15:0] new_heading);
      longint    dl, dr, adv, dang, cos_q, sin_q, ls, as, lin_acc, ang_acc, axle, shifted;
      odo_pose_t p;
      lin_acc = 0;
      ang_acc = 0;
      case (kind)
         REQ_LEFT:  left_count  = (a == b) ? left_count + 1 : left_count - 1;
         REQ_RIGHT: right_count = (a == b) ? right_count + 1 : right_count - 1;
         REQ_LOAD: begin
            x_pos = new_x;
            y_pos = new_y;
            angle = new_heading;
         end
         default: begin
            dl = wheel_delta(left_count, left_seen);
            dr = wheel_delta(right_count, right_seen);
            left_seen  = left_count;
            right_seen = right_count;
            adv  = ((dl + dr) * longint'(mm_per_pulse)) >>> 9;
            axle = (axle_length == 0) ? 1 : longint'(axle_length);
            dang = floor_div((dr - dl) * longint'(mm_per_pulse) * 166886, axle * 4096);
            angle = angle + dang[15:0];
            rotate(angle, cos_q, sin_q);
            shifted = (adv * sin_q) >>> 24;
            x_pos = x_pos - shifted[31:0];
            shifted = (adv * cos_q) >>> 24;
            y_pos = y_pos + shifted[31:0];
            if (elapsed != 0) begin
               ls = adv * 1000 / longint'(elapsed);
               as = dang * 1000 / longint'(elapsed);
               lin_acc = (ls - lin_speed) / longint'(elapsed);
               ang_acc = (as - ang_speed) / longint'(elapsed);
               // The held speeds are the saturated ones.
               lin_speed = longint'(signed'(clamp32(ls)));
               ang_speed = longint'(signed'(clamp32(as)));
            end
            p.pos_x         = x_pos;
            p.pos_y         = y_pos;
            p.heading       = angle;
            p.linear_speed  = lin_speed[31:0];
            p.angular_speed = ang_speed[31:0];
            p.linear_accel  = clamp32(lin_acc);
            p.angular_accel = clamp32(ang_acc);
            p.zero_interval = (elapsed == 0);
            pending_poses.push_back(p);
         end
      endcase
   endfunction

   function void compare(string field, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expected, actual);
         fails++;
      end
   endfunction

   function void check_word(logic [RSP_DATA_BITS-1:0] d);
      odo_pose_t p;
      if (pending_poses.size() == 0) begin
         $display("%0t: unexpected result word, expected none, actual %h", $time, d);
         fails++;
         return;
      end
      p = pending_poses.pop_front();
      compare("pos_x", p.pos_x, d[31:0]);
      compare("pos_y", p.pos_y, d[63:32]);
      compare("heading", {16'h0, p.heading}, {16'h0, d[79:64]});
      compare("linear_speed", p.linear_speed, d[111:80]);
      compare("angular_speed", p.angular_speed, d[143:112]);
      compare("linear_accel", p.linear_accel, d[175:144]);
      compare("angular_accel", p.angular_accel, d[207:176]);
      compare("zero_interval", {31'h0, p.zero_interval}, {31'h0, d[208]});
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT = 3000000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0]               req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic                     csr_index = 1'b0;
   logic [19:0]              csr_data = '0;

   odometry_scoreboard pose_board = new;
   int                 tx_idle_pct = 0;
   int                 rx_idle_pct = 0;
   int                 cycles = 0;

   encoder_odometry_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // An 8-unit clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver stalls at random, as often as the current phase asks.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Every delivered result word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         pose_board.check_word(rsp_tdata);
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[encoder_odometry_top] ERROR");
         $finish;
      end
   end

   // Offers one input word and holds it until the block takes it. The valid is left high
   // afterwards so that back-to-back words need only one assignment per edge.
   task automatic send_word(req_kind_type kind, logic a, logic b, logic [15:0] elapsed,
                            logic [31:0] new_x, logic [31:0] new_y, logic [15:0] new_heading);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'h00, new_heading, new_y, new_x, elapsed, b, a};
      do @(posedge clock); while (!req_tready);
      pose_board.note_word(kind, a, b, elapsed, new_x, new_y, new_heading);
   endtask

   // Drops the valid and waits until every predicted result has been delivered.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pose_board.pending_poses.size() != 0) @(posedge clock);
      // Edge and load words finish at once, so a short settle is plenty.
      repeat (16) @(posedge clock);
   endtask

   task automatic write_register(logic index, logic [19:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pose_board.set_register(index, value);
   endtask

   // An edge word for either wheel, with noise in the fields that it does not use.
   task automatic send_edge(req_kind_type wheel, bit up);
      logic a;
      a = $urandom_range(1);
      send_word(wheel, a, up ? a : ~a, $urandom, $urandom, $urandom, $urandom);
   endtask

   function automatic logic [15:0] pick_elapsed();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return $urandom;
         default: return $urandom_range(1, 50);
      endcase
   endfunction

   // Mostly bursts of edges closed by a tick, so that the speeds and heading move far;
   // the rest are pose loads, lone ticks and stray edges.
   task automatic random_phase(int word_count);
      int          sent;
      int          burst;
      bit          left_up, right_up;
      int          choice;
      sent = 0;
      while (sent < word_count) begin
         choice = $urandom_range(99);
         if (choice < 80) begin
            burst    = $urandom_range(0, 30);
            left_up  = $urandom_range(1);
            right_up = $urandom_range(1);
            repeat (burst) begin
               if ($urandom_range(1)) send_edge(REQ_LEFT, $urandom_range(9) ? left_up : !left_up);
               else send_edge(REQ_RIGHT, $urandom_range(9) ? right_up : !right_up);
            end
            send_word(REQ_TICK, $urandom, $urandom, pick_elapsed(), $urandom, $urandom,
                      $urandom);
            sent += burst + 1;
         end else if (choice < 90) begin
            send_word(REQ_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            sent++;
         end else if (choice < 95) begin
            send_word(REQ_TICK, $urandom, $urandom, pick_elapsed(), $urandom, $urandom,
                      $urandom);
            sent++;
         end else begin
            send_edge(req_kind_type'($urandom_range(1)), $urandom_range(1));
            sent++;
         end
      end
   endtask

   initial begin
      pose_board.clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: edges on both wheels in both directions, ticks at the
      // interval extremes including zero, pose loads at the field extremes and a
      // heading that wraps past a full turn.
      tx_idle_pct = 27;
      rx_idle_pct = 65;
      send_word(REQ_LEFT, 1'b0, 1'b0, 16'h0, 32'h0, 32'h0, 16'h0);
      send_word(REQ_LEFT, 1'b1, 1'b1, 16'h0, 32'h0, 32'h0, 16'h0);
      send_word(REQ_LEFT, 1'b0, 1'b1, 16'h0, 32'h0, 32'h0, 16'h0);
      send_word(REQ_RIGHT, 1'b1, 1'b0, 16'h0, 32'h0, 32'h0, 16'h0);
      send_word(REQ_RIGHT, 1'b1, 1'b1, 16'h0, 32'h0, 32'h0, 16'h0);
      send_word(REQ_RIGHT, 1'b0, 1'b0, 16'h0, 32'h0, 32'h0, 16'h0);
      send_word(REQ_TICK, 1'b0, 1'b0, 16'd1, 32'h0, 32'h0, 16'h0);
      send_word(REQ_TICK, 1'b0, 1'b0, 16'd0, 32'h0, 32'h0, 16'h0);
      send_word(REQ_TICK, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(REQ_LOAD, 1'b1, 1'b1, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFF0);
      repeat (6) send_word(REQ_RIGHT, 1'b1, 1'b1, 16'h0, 32'h0, 32'h0, 16'h0);
      send_word(REQ_TICK, 1'b0, 1'b0, 16'd10, 32'h0, 32'h0, 16'h0);
      send_word(REQ_LOAD, 1'b0, 1'b0, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
      send_word(REQ_LEFT, 1'b1, 1'b1, 16'h0, 32'h0, 32'h0, 16'h0);
      send_word(REQ_TICK, 1'b0, 1'b0, 16'd0, 32'h0, 32'h0, 16'h0);
      // Hold off until the block has emptied at least once.
      drain();

      random_phase(200);

      // Second phase: widest wheel travel with a zero axle, which counts as one.
      tx_idle_pct = 65;
      rx_idle_pct = 27;
      write_register(CSR_MM_PER_PULSE, 20'hFFFFF);
      write_register(CSR_AXLE_LENGTH, {4'hF, 16'h0000});
      random_phase(200);

      // Third phase: the narrowest travel and the widest axle, then a random pair.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_register(CSR_MM_PER_PULSE, 20'd1);
      write_register(CSR_AXLE_LENGTH, 20'd65535);
      random_phase(100);
      write_register(CSR_MM_PER_PULSE, $urandom_range(1, 20'hFFFFF));
      write_register(CSR_AXLE_LENGTH, $urandom_range(256, 65535));
      random_phase(100);

      drain();
      repeat (600) @(posedge clock);
      if (pose_board.fails == 0) begin
         $display("[encoder_odometry_top] OK");
      end else begin
         $display("[encoder_odometry_top] ERROR");
      end
      $finish;
   end

endmodule

/* encoder_odometry_top.f */
src/eo_pkg.sv
src/eo_alu.sv
src/eo_cordic.sv
src/encoder_odometry_top.sv
verif/testbench.sv
